// File: hw/rtl/slpg_pkg.sv
// Package for the status LED pattern generator.
// Holds the action codes, the pattern ROM and the shared item/result types.
// No dependencies.
package slpg_pkg;

    localparam int unsigned STATE_W = 3;
    localparam int unsigned REQ_W   = 4;
    localparam int unsigned PHASE_W = 11;
    localparam int unsigned SPAN_W  = 12;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_INIT = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]       action;
        logic [REQ_W-1:0] new_state;
    } t_item;

    typedef struct packed {
        logic blue;
        logic green;
        logic red;
        logic led_on;
    } t_result;

    // step = on + gap
    typedef struct packed {
        logic [PHASE_W-1:0] period;
        logic [PHASE_W-1:0] on_len;
        logic [PHASE_W-1:0] step;
        logic [1:0]         count;
        logic               cr;
        logic               cg;
        logic               cb;
    } t_pat_row;

    function automatic t_pat_row pat_rom(input logic [STATE_W-1:0] idx);
        t_pat_row r;
        case (idx)
            3'd0:    r = '{11'd500,  11'd500, 11'd500, 2'd1, 1'b0, 1'b0, 1'b1};
            3'd1:    r = '{11'd250,  11'd125, 11'd125, 2'd1, 1'b0, 1'b1, 1'b1};
            3'd2:    r = '{11'd1000, 11'd50,  11'd50,  2'd1, 1'b0, 1'b1, 1'b0};
            3'd3:    r = '{11'd500,  11'd250, 11'd250, 2'd1, 1'b1, 1'b1, 1'b0};
            3'd4:    r = '{11'd1500, 11'd90,  11'd250, 2'd2, 1'b1, 1'b1, 1'b0};
            3'd5:    r = '{11'd1200, 11'd110, 11'd270, 2'd3, 1'b1, 1'b0, 1'b0};
            3'd6:    r = '{11'd160,  11'd80,  11'd80,  2'd1, 1'b1, 1'b0, 1'b0};
            default: r = '{11'd500,  11'd500, 11'd500, 2'd1, 1'b1, 1'b0, 1'b1};
        endcase
        return r;
    endfunction

    function automatic logic is_fault(input logic [REQ_W-1:0] s);
        return (s == 4'd5) || (s == 4'd6);
    endfunction

endpackage

// File: hw/rtl/slpg_in_stage.sv
// Input register of the status LED pattern generator.
// Holds one request until the core consumes it. Uses slpg_pkg.
module slpg_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slpg_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output slpg_pkg::t_item o_item
);

    logic            r_valid;
    slpg_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hw/rtl/slpg_core.sv
// State, phase counter and pulse decode of the status LED pattern generator.
// Applies one request per fire; result is combinational. Uses slpg_pkg.
module slpg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  slpg_pkg::t_item   i_item,
    output logic              o_emit,
    output slpg_pkg::t_result o_result
);

    logic [slpg_pkg::STATE_W-1:0] r_state, n_state;
    logic [slpg_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                         r_init, n_init;

    slpg_pkg::t_pat_row           row;
    logic [slpg_pkg::PHASE_W-1:0] tick_phase;
    logic [slpg_pkg::SPAN_W-1:0]  ph_ext;
    logic [slpg_pkg::SPAN_W-1:0]  start1, start2;
    logic                         hit0, hit1, hit2, lvl;
    logic                         set_ok;

    always_comb begin
        row        = slpg_pkg::pat_rom(r_state);
        tick_phase = r_phase + 1'b1;
        if (tick_phase >= row.period) begin
            tick_phase = '0;
        end
        ph_ext = {1'b0, tick_phase};
        start1 = {1'b0, row.step};
        start2 = {row.step, 1'b0};
        hit0   = ph_ext < {1'b0, row.on_len};
        hit1   = (row.count >= 2'd2) && (ph_ext >= start1)
                 && (ph_ext < start1 + {1'b0, row.on_len});
        hit2   = (row.count == 2'd3) && (ph_ext >= start2)
                 && (ph_ext < start2 + {1'b0, row.on_len});
        lvl    = hit0 || hit1 || hit2;

        o_result.led_on = lvl;
        o_result.red    = lvl & row.cr;
        o_result.green  = lvl & row.cg;
        o_result.blue   = lvl & row.cb;

        o_emit = (slpg_pkg::t_action'(i_item.action) == slpg_pkg::ACT_TICK) && r_init;

        set_ok = !i_item.new_state[3]
                 && !(slpg_pkg::is_fault({1'b0, r_state})
                      && !slpg_pkg::is_fault(i_item.new_state))
                 && (i_item.new_state[2:0] != r_state);

        n_state = r_state;
        n_phase = r_phase;
        n_init  = r_init;
        case (slpg_pkg::t_action'(i_item.action))
            slpg_pkg::ACT_INIT: begin
                n_state = '0;
                n_phase = '0;
                n_init  = 1'b1;
            end
            slpg_pkg::ACT_SET: begin
                if (set_ok) begin
                    n_state = i_item.new_state[2:0];
                    n_phase = '0;
                end
            end
            slpg_pkg::ACT_TICK: begin
                if (r_init) begin
                    n_phase = tick_phase;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_phase <= '0;
            r_init  <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_init  <= n_init;
        end
    end

endmodule

// File: hw/rtl/slpg_out_reg.sv
// Output register of the status LED pattern generator.
// Holds one result until the sink takes it. Uses slpg_pkg.
module slpg_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  slpg_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output slpg_pkg::t_result o_result
);

    logic              r_valid;
    slpg_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/status_led_pattern_generator.sv
// Status LED pattern generator, top level.
// A tick request is held in the input register; its result is loaded into the output register when the core fires it.
// Throughput: one request per cycle; a waiting result holds back a tick and all behind it.
// Requests that give no result pass through the core without an output slot.
// Synchronous active-low reset clears state, phase, init flag and valids.
// Uses slpg_pkg, slpg_in_stage, slpg_core, slpg_out_reg.
module status_led_pattern_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [3:0] new_state, [7:4] zero
    input  logic [1:0] i_s_tuser,   // [1:0] action
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] led_on, [1] red, [2] green, [3] blue, [7:4] zero
);

    slpg_pkg::t_item   in_item, st_item;
    slpg_pkg::t_result core_res, out_res;
    logic              st_valid, emit, out_free, fire;

    assign in_item.action    = i_s_tuser;
    assign in_item.new_state = i_s_tdata[3:0];

    assign fire = st_valid && (!emit || out_free);

    slpg_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    slpg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (st_item),
        .o_emit   (emit),
        .o_result (core_res)
    );

    slpg_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (core_res),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_res)
    );

    assign o_m_tdata = {4'b0000, out_res.blue, out_res.green, out_res.red, out_res.led_on};

endmodule
